FILE: src/sesq_pkg.sv
// Shared types, codes and tables of the sound event sequencer.
`default_nettype none
package sesq_pkg;

	localparam int MAX_RESULTS    = 24;
	localparam int DRAIN_ROOM     = MAX_RESULTS - 4;
	localparam int CNT_W          = 5;
	localparam int SUSPEND_MARGIN = 30;
	localparam int DUR_W          = 11;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 7;
	localparam int VOL_MAX        = 100;

	localparam logic [2:0] CMD_DONE = 3'd0;
	localparam logic [2:0] CMD_VOL  = 3'd1;
	localparam logic [2:0] CMD_ONCE = 3'd2;
	localparam logic [2:0] CMD_LOOP = 3'd3;
	localparam logic [2:0] CMD_STOP = 3'd4;

	localparam logic [2:0] EV_TOUCH   = 3'd1;
	localparam logic [2:0] EV_CONFIRM = 3'd2;
	localparam logic [2:0] EV_ERROR   = 3'd3;
	localparam logic [2:0] EV_ASTART  = 3'd4;
	localparam logic [2:0] EV_ASTOP   = 3'd5;

	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_POST    = 2'd1;
	localparam logic [1:0] ACT_PREVIEW = 2'd2;
	localparam logic [1:0] ACT_MUTE    = 2'd3;

	localparam logic [1:0] MEL_ALARM = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYS_VOL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_VOL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEL_TOUCH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MEL_CONF   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MEL_ERROR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MEL_ALARM  = 3'd6;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] volume;
		logic [1:0] melody_type;
		logic [2:0] melody_variant;
		logic       post_accepted;
		logic       last;
	} res_t;

	// up to three results produced by one decision, e[0] goes out first
	typedef struct packed {
		res_t [2:0] e;
		logic [1:0] n;
	} plan_t;

	function automatic logic [2:0] fix_variant(input logic [2:0] v);
		return (v >= 3'd6) ? 3'd0 : v;
	endfunction

	// melody length plus the suspend margin
	function automatic logic [DUR_W-1:0] suspend_len(input logic [1:0] t, input logic [2:0] v);
		logic [DUR_W-1:0] d;
		case ({t, v})
			5'b00_000: d = 11'd17;
			5'b00_001: d = 11'd28;
			5'b00_010: d = 11'd10;
			5'b00_011: d = 11'd12;
			5'b00_100: d = 11'd29;
			5'b00_101: d = 11'd30;
			5'b01_000: d = 11'd286;
			5'b01_001: d = 11'd326;
			5'b01_010: d = 11'd266;
			5'b01_011: d = 11'd348;
			5'b01_100: d = 11'd258;
			5'b01_101: d = 11'd284;
			5'b10_000: d = 11'd374;
			5'b10_001: d = 11'd286;
			5'b10_010: d = 11'd554;
			5'b10_011: d = 11'd244;
			5'b10_100: d = 11'd386;
			5'b10_101: d = 11'd202;
			5'b11_000: d = 11'd968;
			5'b11_001: d = 11'd1008;
			5'b11_010: d = 11'd668;
			5'b11_011: d = 11'd904;
			5'b11_100: d = 11'd908;
			5'b11_101: d = 11'd672;
			default:   d = 11'd0;
		endcase
		return d + DUR_W'(SUSPEND_MARGIN);
	endfunction

	function automatic res_t res_make(input logic [2:0] c, input logic [6:0] vol,
	                                  input logic [1:0] t, input logic [2:0] v);
		res_t r;
		r.command        = c;
		r.volume         = vol;
		r.melody_type    = t;
		r.melody_variant = v;
		r.post_accepted  = 1'b0;
		r.last           = 1'b0;
		return r;
	endfunction

	function automatic plan_t plan_none();
		plan_t p;
		p.e = '0;
		p.n = 2'd0;
		return p;
	endfunction

	function automatic plan_t plan_one(input res_t a);
		plan_t p;
		p.e    = '0;
		p.e[0] = a;
		p.n    = 2'd1;
		return p;
	endfunction

	function automatic plan_t plan_two(input res_t a, input res_t b);
		plan_t p;
		p.e    = '0;
		p.e[0] = a;
		p.e[1] = b;
		p.n    = 2'd2;
		return p;
	endfunction

	// system sound: optional stop of a running alarm, volume, play once
	function automatic plan_t plan_system(input logic stop_first, input logic [6:0] vol,
	                                      input logic [1:0] t, input logic [2:0] v);
		plan_t p;
		p.e = '0;
		if (stop_first) begin
			p.e[0] = res_make(CMD_STOP, 7'd0, 2'd0, 3'd0);
			p.e[1] = res_make(CMD_VOL, vol, 2'd0, 3'd0);
			p.e[2] = res_make(CMD_ONCE, 7'd0, t, v);
			p.n    = 2'd3;
		end else begin
			p.e[0] = res_make(CMD_VOL, vol, 2'd0, 3'd0);
			p.e[1] = res_make(CMD_ONCE, 7'd0, t, v);
			p.n    = 2'd2;
		end
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: src/sesq_if.sv
// Handshake channels of the sound event sequencer: request items and result items.
`default_nettype none
interface sesq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [2:0]  event_code;
	logic [2:0]  preview_variant;
	logic        mute_value;
	logic [31:0] now_ms;

	modport source (output valid, action, event_code, preview_variant, mute_value, now_ms,
	                input ready);
	modport sink (input valid, action, event_code, preview_variant, mute_value, now_ms,
	              output ready);
endinterface

interface sesq_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [6:0] volume;
	logic [1:0] melody_type;
	logic [2:0] melody_variant;
	logic       post_accepted;
	logic       last;

	modport source (output valid, command, volume, melody_type, melody_variant,
	                post_accepted, last, input ready);
	modport sink (input valid, command, volume, melody_type, melody_variant,
	              post_accepted, last, output ready);
endinterface
`default_nettype wire

FILE: src/sesq_ring.sv
// Event ring storage: one write port, one registered read port.
`default_nettype none
module sesq_ring #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [2:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [2:0]         rdata
);

	logic [2:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/sesq_out_stage.sv
// Result output register: holds one result item until the sink takes it.
`default_nettype none
module sesq_out_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire sesq_pkg::res_t res,
	output logic               free,
	sesq_res_if.source         result
);

	logic           valid_q;
	sesq_pkg::res_t data_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign result.valid          = valid_q;
	assign result.command        = data_q.command;
	assign result.volume         = data_q.volume;
	assign result.melody_type    = data_q.melody_type;
	assign result.melody_variant = data_q.melody_variant;
	assign result.post_accepted  = data_q.post_accepted;
	assign result.last           = data_q.last;

endmodule
`default_nettype wire

FILE: src/sound_event_sequencer.sv
// Sound event sequencer top level: control sequencer around the event ring.
//
//  channel   dir  kind         payload
//  request   in   valid/ready  action, event_code, preview_variant, mute_value, now_ms
//  result    out  valid/ready  command, volume, melody_type, melody_variant, post_accepted, last
//  cfg       in   write only   cfg_we, cfg_index, cfg_data
//
// One item at a time. An accepted item is dispatched, then its result items go out
// in order as the result register frees. A tick drains queued events one by one
// through a ring read; a touch post scans each queued entry through a ring read.
// Reset clears all control state; ring contents need no clearing.
// A stalled result holds the sequencer; request ready is high only when idle.
`default_nettype none
module sound_event_sequencer #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	sesq_req_if.sink                                request,
	sesq_res_if.source                              result,
	input  wire logic                               cfg_we,
	input  wire logic [sesq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sesq_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DISPATCH = 4'd1;
	localparam logic [3:0] ST_DRAIN    = 4'd2;
	localparam logic [3:0] ST_DRD      = 4'd3;
	localparam logic [3:0] ST_PUSH     = 4'd4;
	localparam logic [3:0] ST_SCAN     = 4'd5;
	localparam logic [3:0] ST_SCHK     = 4'd6;
	localparam logic [3:0] ST_WRITE    = 4'd7;
	localparam logic [3:0] ST_EMIT     = 4'd8;
	localparam logic [3:0] ST_DONE     = 4'd9;

	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [3:0] enable_q;
	logic [6:0] sys_vol_q, alarm_vol_q;
	logic [2:0] mel_touch_q, mel_conf_q, mel_error_q, mel_alarm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 4'd15;
			sys_vol_q   <= 7'd70;
			alarm_vol_q <= 7'd70;
			mel_touch_q <= 3'd0;
			mel_conf_q  <= 3'd0;
			mel_error_q <= 3'd0;
			mel_alarm_q <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				sesq_pkg::REG_ENABLE:    enable_q    <= cfg_data[3:0];
				sesq_pkg::REG_SYS_VOL:   sys_vol_q   <= (cfg_data > 7'(sesq_pkg::VOL_MAX)) ?
				                                         7'(sesq_pkg::VOL_MAX) : cfg_data;
				sesq_pkg::REG_ALARM_VOL: alarm_vol_q <= (cfg_data > 7'(sesq_pkg::VOL_MAX)) ?
				                                         7'(sesq_pkg::VOL_MAX) : cfg_data;
				sesq_pkg::REG_MEL_TOUCH: mel_touch_q <= cfg_data[2:0];
				sesq_pkg::REG_MEL_CONF:  mel_conf_q  <= cfg_data[2:0];
				sesq_pkg::REG_MEL_ERROR: mel_error_q <= cfg_data[2:0];
				sesq_pkg::REG_MEL_ALARM: mel_alarm_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// control state
	logic [3:0]                state_q, state_d, ret_q, ret_d;
	logic [IDX_W-1:0]          head_q, head_d, tail_q, tail_d, scan_q, scan_d;
	logic                      active_q, active_d, susp_q, susp_d, muted_q, muted_d;
	logic                      acc_q, acc_d;
	logic [31:0]               resume_q, resume_d;
	logic [sesq_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]                idx_q, idx_d;

	// item fields and pending results
	logic [1:0]      act_q;
	logic [2:0]      ev_q, pvar_q;
	logic            mv_q;
	logic [31:0]     now_q;
	sesq_pkg::plan_t plan_q, plan_d;

	// ring and output stage
	logic             ring_we, ring_re;
	logic [IDX_W-1:0] ring_raddr;
	logic [2:0]       ring_rdata;
	logic             out_load, out_free;
	sesq_pkg::res_t   out_res;

	logic [2:0] var_alarm;
	logic       alarm_ok;

	assign var_alarm = sesq_pkg::fix_variant(mel_alarm_q);
	assign alarm_ok  = enable_q[3] && !muted_q;
	assign request.ready = (state_q == ST_IDLE);

	always_comb begin
		sesq_pkg::plan_t pl;
		logic            decide;
		logic [3:0]      ret;
		logic            sys_go;
		logic [1:0]      sys_t;
		logic [2:0]      sys_v;
		logic [2:0]      var_of;
		sesq_pkg::res_t  done_res;

		pl      = sesq_pkg::plan_none();
		decide  = 1'b0;
		ret     = ST_DONE;
		sys_go  = 1'b0;
		sys_t   = 2'd0;
		sys_v   = 3'd0;
		var_of  = 3'd0;
		done_res = sesq_pkg::res_make(sesq_pkg::CMD_DONE, 7'd0, 2'd0, 3'd0);

		state_d  = state_q;
		ret_d    = ret_q;
		head_d   = head_q;
		tail_d   = tail_q;
		scan_d   = scan_q;
		active_d = active_q;
		susp_d   = susp_q;
		muted_d  = muted_q;
		acc_d    = acc_q;
		resume_d = resume_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		plan_d   = plan_q;

		ring_we    = 1'b0;
		ring_re    = 1'b0;
		ring_raddr = tail_q;
		out_load   = 1'b0;
		out_res    = plan_q.e[idx_q];

		case (state_q)
			ST_IDLE: begin
				if (request.valid) begin
					cnt_d   = '0;
					acc_d   = 1'b0;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				decide = 1'b1;
				case (act_q)
					sesq_pkg::ACT_TICK: begin
						ret = ST_DRAIN;
						if (susp_q && now_q >= resume_q) begin
							susp_d = 1'b0;
							if (active_q && alarm_ok) begin
								pl = sesq_pkg::plan_two(
									sesq_pkg::res_make(sesq_pkg::CMD_VOL, alarm_vol_q, 2'd0, 3'd0),
									sesq_pkg::res_make(sesq_pkg::CMD_LOOP, 7'd0,
									                   sesq_pkg::MEL_ALARM, var_alarm));
							end
						end
					end
					sesq_pkg::ACT_POST: begin
						case (ev_q)
							sesq_pkg::EV_ASTOP: begin
								active_d = 1'b0;
								susp_d   = 1'b0;
								head_d   = '0;
								tail_d   = '0;
								pl = sesq_pkg::plan_one(
									sesq_pkg::res_make(sesq_pkg::CMD_STOP, 7'd0, 2'd0, 3'd0));
							end
							sesq_pkg::EV_ASTART: begin
								susp_d = 1'b0;
								head_d = '0;
								tail_d = '0;
								ret    = ST_PUSH;
								pl = sesq_pkg::plan_one(
									sesq_pkg::res_make(sesq_pkg::CMD_STOP, 7'd0, 2'd0, 3'd0));
							end
							sesq_pkg::EV_TOUCH, sesq_pkg::EV_CONFIRM, sesq_pkg::EV_ERROR: begin
								ret = ST_PUSH;
							end
							default: ;
						endcase
					end
					sesq_pkg::ACT_PREVIEW: begin
						if (!muted_q && ev_q != 3'd0 && ev_q <= sesq_pkg::EV_ASTART) begin
							head_d = '0;
							tail_d = '0;
							if (ev_q == sesq_pkg::EV_ASTART) begin
								pl = sesq_pkg::plan_two(
									sesq_pkg::res_make(sesq_pkg::CMD_VOL, alarm_vol_q, 2'd0, 3'd0),
									sesq_pkg::res_make(sesq_pkg::CMD_ONCE, 7'd0, sesq_pkg::MEL_ALARM,
									                   sesq_pkg::fix_variant(pvar_q)));
							end else begin
								sys_go = 1'b1;
								sys_t  = 2'(ev_q - 3'd1);
								sys_v  = sesq_pkg::fix_variant(pvar_q);
							end
						end
					end
					sesq_pkg::ACT_MUTE: begin
						muted_d = mv_q;
						if (mv_q && active_q) begin
							susp_d = 1'b0;
							head_d = '0;
							tail_d = '0;
							pl = sesq_pkg::plan_one(
								sesq_pkg::res_make(sesq_pkg::CMD_STOP, 7'd0, 2'd0, 3'd0));
						end else if (!mv_q && muted_q && active_q && enable_q[3]) begin
							susp_d = 1'b0;
							pl = sesq_pkg::plan_two(
								sesq_pkg::res_make(sesq_pkg::CMD_VOL, alarm_vol_q, 2'd0, 3'd0),
								sesq_pkg::res_make(sesq_pkg::CMD_LOOP, 7'd0,
								                   sesq_pkg::MEL_ALARM, var_alarm));
						end
					end
					default: ;
				endcase
			end
			ST_DRAIN: begin
				if (head_q != tail_q && cnt_q <= sesq_pkg::CNT_W'(sesq_pkg::DRAIN_ROOM)) begin
					ring_re    = 1'b1;
					ring_raddr = tail_q;
					tail_d     = ptr_inc(tail_q);
					state_d    = ST_DRD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DRD: begin
				decide = 1'b1;
				ret    = ST_DRAIN;
				case (ring_rdata)
					sesq_pkg::EV_TOUCH, sesq_pkg::EV_CONFIRM, sesq_pkg::EV_ERROR: begin
						sys_t = 2'(ring_rdata - 3'd1);
						case (sys_t)
							2'd0:    var_of = sesq_pkg::fix_variant(mel_touch_q);
							2'd1:    var_of = sesq_pkg::fix_variant(mel_conf_q);
							default: var_of = sesq_pkg::fix_variant(mel_error_q);
						endcase
						sys_v  = var_of;
						sys_go = enable_q[sys_t] && !muted_q;
					end
					sesq_pkg::EV_ASTART: begin
						active_d = 1'b1;
						susp_d   = 1'b0;
						if (alarm_ok) begin
							pl = sesq_pkg::plan_two(
								sesq_pkg::res_make(sesq_pkg::CMD_VOL, alarm_vol_q, 2'd0, 3'd0),
								sesq_pkg::res_make(sesq_pkg::CMD_LOOP, 7'd0,
								                   sesq_pkg::MEL_ALARM, var_alarm));
						end
					end
					sesq_pkg::EV_ASTOP: begin
						active_d = 1'b0;
						susp_d   = 1'b0;
						pl = sesq_pkg::plan_two(
							sesq_pkg::res_make(sesq_pkg::CMD_STOP, 7'd0, 2'd0, 3'd0),
							sesq_pkg::res_make(sesq_pkg::CMD_VOL, sys_vol_q, 2'd0, 3'd0));
					end
					default: ;
				endcase
			end
			ST_PUSH: begin
				if (ptr_inc(head_q) == tail_q) begin
					state_d = ST_DONE;
				end else if (ev_q == sesq_pkg::EV_TOUCH) begin
					scan_d  = tail_q;
					state_d = ST_SCAN;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_SCAN: begin
				if (scan_q == head_q) begin
					state_d = ST_WRITE;
				end else begin
					ring_re    = 1'b1;
					ring_raddr = scan_q;
					scan_d     = ptr_inc(scan_q);
					state_d    = ST_SCHK;
				end
			end
			ST_SCHK: begin
				// a touch already queued refuses the new one
				state_d = (ring_rdata == sesq_pkg::EV_TOUCH) ? ST_DONE : ST_SCAN;
			end
			ST_WRITE: begin
				ring_we = 1'b1;
				head_d  = ptr_inc(head_q);
				acc_d   = 1'b1;
				state_d = ST_DONE;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					cnt_d    = cnt_q + 1'b1;
					idx_d    = idx_q + 1'b1;
					if (idx_q == plan_q.n - 2'd1) begin
						state_d = ret_q;
					end
				end
			end
			ST_DONE: begin
				done_res.post_accepted = acc_q;
				done_res.last          = 1'b1;
				out_res                = done_res;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// system sound shared by drain and preview
		if (sys_go) begin
			pl = sesq_pkg::plan_system(active_q && !susp_q, sys_vol_q, sys_t, sys_v);
			if (active_q) begin
				susp_d   = 1'b1;
				resume_d = now_q + 32'(sesq_pkg::suspend_len(sys_t, sys_v));
			end
		end

		if (decide) begin
			plan_d = pl;
			idx_d  = 2'd0;
			if (pl.n == 2'd0) begin
				state_d = ret;
			end else begin
				state_d = ST_EMIT;
				ret_d   = ret;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_DONE;
			head_q   <= '0;
			tail_q   <= '0;
			scan_q   <= '0;
			active_q <= 1'b0;
			susp_q   <= 1'b0;
			muted_q  <= 1'b0;
			acc_q    <= 1'b0;
			resume_q <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			scan_q   <= scan_d;
			active_q <= active_d;
			susp_q   <= susp_d;
			muted_q  <= muted_d;
			acc_q    <= acc_d;
			resume_q <= resume_d;
			cnt_q    <= cnt_d;
			idx_q    <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			act_q  <= request.action;
			ev_q   <= request.event_code;
			pvar_q <= request.preview_variant;
			mv_q   <= request.mute_value;
			now_q  <= request.now_ms;
		end
		plan_q <= plan_d;
	end

	sesq_ring #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (IDX_W)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (head_q),
		.wdata (ev_q),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	sesq_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.res    (out_res),
		.free   (out_free),
		.result (result)
	);

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready |=> state_q == ST_DISPATCH)
		else $error("accepted item did not start dispatch");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ring_we |-> ptr_inc(head_q) != tail_q)
		else $error("ring written while full");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten");

	a_result_budget: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> cnt_q < sesq_pkg::CNT_W'(sesq_pkg::MAX_RESULTS))
		else $error("too many results for one item");

	a_done_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> state_q == ST_IDLE)
		else $error("done result did not return to idle");

endmodule
`default_nettype wire

FILE: test/tb_sound_event_sequencer.sv
// Self-checking testbench of the sound event sequencer: directed table, then random phases.
`timescale 1ns / 1ps
module tb_sound_event_sequencer;

	localparam int QD          = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 52;

	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_SPARE6 = 3'd6;
	localparam logic [2:0] EV_SPARE7 = 3'd7;
	localparam logic [sesq_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	// melody lengths in ms, indexed [type][variant]
	localparam logic [0:3][0:5][10:0] MELODY_MS = {
		{11'd17,  11'd28,   11'd10,  11'd12,  11'd29,  11'd30},
		{11'd286, 11'd326,  11'd266, 11'd348, 11'd258, 11'd284},
		{11'd374, 11'd286,  11'd554, 11'd244, 11'd386, 11'd202},
		{11'd968, 11'd1008, 11'd668, 11'd904, 11'd908, 11'd672}
	};

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  event_code;
		logic [2:0]  pvar;
		logic        mute_value;
		logic [31:0] now_ms;
	} req_item_t;

	typedef struct {
		req_item_t      it;
		int             n_typed;
		sesq_pkg::res_t r0;
		sesq_pkg::res_t r1;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [sesq_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sesq_pkg::CFG_DATA_W-1:0] cfg_data;

	sesq_req_if req();
	sesq_res_if res();

	sound_event_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.request(req),
		.result(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of configuration and state
	logic [3:0]  cfg_enable;
	logic [6:0]  cfg_sys_vol;
	logic [6:0]  cfg_alarm_vol;
	logic [2:0]  cfg_mel [4];
	logic [2:0]  ring_ev [QD];
	int          ring_head;
	int          ring_tail;
	bit          alarm_on;
	bit          alarm_held;
	bit          is_muted;
	logic [31:0] resume_at;
	int          n_out;

	sesq_pkg::res_t step_cmds[$];
	sesq_pkg::res_t expected_cmds[$];
	dir_row_t       dir_rows[$];

	int          err_count;
	int          res_seen;
	int          stuck_cycles;
	bit          no_idle;
	logic [31:0] now_base;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sesq_pkg::res_t cmd_res(logic [2:0] c, logic [6:0] vol, logic [1:0] t,
	                                           logic [2:0] v, logic pa, logic lst);
		sesq_pkg::res_t r;
		r.command        = c;
		r.volume         = vol;
		r.melody_type    = t;
		r.melody_variant = v;
		r.post_accepted  = pa;
		r.last           = lst;
		return r;
	endfunction

	function automatic string show_cmd(sesq_pkg::res_t r);
		return $sformatf("cmd=%0d vol=%0d type=%0d var=%0d acc=%0d last=%0d", r.command,
		                 r.volume, r.melody_type, r.melody_variant, r.post_accepted, r.last);
	endfunction

	function automatic void log_error(string msg);
		err_count++;
		if (err_count <= 10)
			$display("ERROR: %s", msg);
	endfunction

	function automatic logic [2:0] clamp_variant(logic [2:0] v);
		return (v >= 3'd6) ? 3'd0 : v;
	endfunction

	function automatic void emit_cmd(logic [2:0] c, logic [6:0] vol, logic [1:0] t,
	                                 logic [2:0] v);
		step_cmds.push_back(cmd_res(c, vol, t, v, 1'b0, 1'b0));
		n_out++;
	endfunction

	function automatic void start_loop();
		emit_cmd(sesq_pkg::CMD_VOL, cfg_alarm_vol, 2'd0, 3'd0);
		emit_cmd(sesq_pkg::CMD_LOOP, 7'd0, sesq_pkg::MEL_ALARM, clamp_variant(cfg_mel[3]));
	endfunction

	function automatic void play_system(logic [1:0] t, logic [2:0] v, logic [31:0] now);
		if (alarm_on && !alarm_held)
			emit_cmd(sesq_pkg::CMD_STOP, 7'd0, 2'd0, 3'd0);
		emit_cmd(sesq_pkg::CMD_VOL, cfg_sys_vol, 2'd0, 3'd0);
		emit_cmd(sesq_pkg::CMD_ONCE, 7'd0, t, v);
		// a system sound over the alarm parks it until the melody and the suspend margin are over
		if (alarm_on) begin
			alarm_held = 1'b1;
			resume_at  = now + 32'(MELODY_MS[t][v]) + 32'(sesq_pkg::SUSPEND_MARGIN);
		end
	endfunction

	function automatic bit ring_push(logic [2:0] ev);
		int nxt;
		int i;
		nxt = (ring_head + 1) % QD;
		if (nxt == ring_tail)
			return 1'b0;
		if (ev == sesq_pkg::EV_TOUCH)
			for (i = ring_tail; i != ring_head; i = (i + 1) % QD)
				if (ring_ev[i] == sesq_pkg::EV_TOUCH)
					return 1'b0;
		ring_ev[ring_head] = ev;
		ring_head          = nxt;
		return 1'b1;
	endfunction

	function automatic void tick_drain(logic [31:0] now);
		logic [2:0] ev;
		logic [1:0] t;
		if (alarm_held && now >= resume_at) begin
			alarm_held = 1'b0;
			if (alarm_on && cfg_enable[3] && !is_muted)
				start_loop();
		end
		while (ring_head != ring_tail && n_out <= sesq_pkg::DRAIN_ROOM) begin
			ev        = ring_ev[ring_tail];
			ring_tail = (ring_tail + 1) % QD;
			if (ev >= sesq_pkg::EV_TOUCH && ev <= sesq_pkg::EV_ERROR) begin
				t = ev[1:0] - 2'd1;
				if (cfg_enable[t] && !is_muted)
					play_system(t, clamp_variant(cfg_mel[t]), now);
			end else if (ev == sesq_pkg::EV_ASTART) begin
				alarm_on   = 1'b1;
				alarm_held = 1'b0;
				if (cfg_enable[3] && !is_muted)
					start_loop();
			end else if (ev == sesq_pkg::EV_ASTOP) begin
				alarm_on   = 1'b0;
				alarm_held = 1'b0;
				emit_cmd(sesq_pkg::CMD_STOP, 7'd0, 2'd0, 3'd0);
				emit_cmd(sesq_pkg::CMD_VOL, cfg_sys_vol, 2'd0, 3'd0);
			end
		end
	endfunction

	function automatic bit post_event(logic [2:0] ev);
		if (ev == EV_NONE || ev > sesq_pkg::EV_ASTOP)
			return 1'b0;
		if (ev == sesq_pkg::EV_ASTOP) begin
			alarm_on   = 1'b0;
			alarm_held = 1'b0;
			emit_cmd(sesq_pkg::CMD_STOP, 7'd0, 2'd0, 3'd0);
			ring_head = 0;
			ring_tail = 0;
			return 1'b0;
		end
		if (ev == sesq_pkg::EV_ASTART) begin
			alarm_held = 1'b0;
			emit_cmd(sesq_pkg::CMD_STOP, 7'd0, 2'd0, 3'd0);
			ring_head = 0;
			ring_tail = 0;
		end
		return ring_push(ev);
	endfunction

	function automatic void preview_melody(logic [2:0] ev, logic [2:0] pv, logic [31:0] now);
		logic [2:0] v;
		if (is_muted || ev == EV_NONE || ev > sesq_pkg::EV_ASTART)
			return;
		v         = clamp_variant(pv);
		ring_head = 0;
		ring_tail = 0;
		if (ev == sesq_pkg::EV_ASTART) begin
			emit_cmd(sesq_pkg::CMD_VOL, cfg_alarm_vol, 2'd0, 3'd0);
			emit_cmd(sesq_pkg::CMD_ONCE, 7'd0, sesq_pkg::MEL_ALARM, v);
		end else begin
			play_system(ev[1:0] - 2'd1, v, now);
		end
	endfunction

	function automatic void set_mute(logic m);
		bit was;
		was      = is_muted;
		is_muted = m;
		if (is_muted && alarm_on) begin
			alarm_held = 1'b0;
			emit_cmd(sesq_pkg::CMD_STOP, 7'd0, 2'd0, 3'd0);
			ring_head = 0;
			ring_tail = 0;
		end else if (!is_muted && was && alarm_on && cfg_enable[3]) begin
			alarm_held = 1'b0;
			start_loop();
		end
	endfunction

	function automatic void compute_buzzer_cmds(req_item_t it);
		bit acc;
		acc = 1'b0;
		step_cmds.delete();
		n_out = 0;
		case (it.action)
			sesq_pkg::ACT_TICK:    tick_drain(it.now_ms);
			sesq_pkg::ACT_POST:    acc = post_event(it.event_code);
			sesq_pkg::ACT_PREVIEW: preview_melody(it.event_code, it.pvar, it.now_ms);
			default:               set_mute(it.mute_value);
		endcase
		step_cmds.push_back(cmd_res(sesq_pkg::CMD_DONE, 7'd0, 2'd0, 3'd0, acc, 1'b1));
	endfunction

	function automatic void apply_reg(logic [sesq_pkg::CFG_IDX_W-1:0] idx,
	                                  logic [sesq_pkg::CFG_DATA_W-1:0] d);
		case (idx)
			sesq_pkg::REG_ENABLE:    cfg_enable    = d[3:0];
			sesq_pkg::REG_SYS_VOL:   cfg_sys_vol   = (d > sesq_pkg::VOL_MAX) ?
			                                         7'(sesq_pkg::VOL_MAX) : d;
			sesq_pkg::REG_ALARM_VOL: cfg_alarm_vol = (d > sesq_pkg::VOL_MAX) ?
			                                         7'(sesq_pkg::VOL_MAX) : d;
			sesq_pkg::REG_MEL_TOUCH: cfg_mel[0]    = d[2:0];
			sesq_pkg::REG_MEL_CONF:  cfg_mel[1]    = d[2:0];
			sesq_pkg::REG_MEL_ERROR: cfg_mel[2]    = d[2:0];
			sesq_pkg::REG_MEL_ALARM: cfg_mel[3]    = d[2:0];
			default: ;
		endcase
	endfunction

	function automatic void add_row(logic [1:0] a, logic [2:0] ev, logic [2:0] pv, logic mv,
	                                logic [31:0] now, int n, sesq_pkg::res_t r0,
	                                sesq_pkg::res_t r1);
		dir_row_t row;
		row.it      = {a, ev, pv, mv, now};
		row.n_typed = n;
		row.r0      = r0;
		row.r1      = r1;
		dir_rows.push_back(row);
	endfunction

	// mostly well-formed posts and ticks on a running clock, some noise
	function automatic req_item_t random_item();
		req_item_t it;
		int k;
		int r;
		it.event_code = 3'($urandom_range(0, 7));
		it.pvar       = 3'($urandom_range(0, 7));
		it.mute_value = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 19) == 0)
			now_base = $urandom;
		else
			now_base = now_base + 32'($urandom_range(0, 700));
		it.now_ms = now_base;
		k = $urandom_range(0, 99);
		if (k < 48) begin
			it.action = sesq_pkg::ACT_POST;
			r = $urandom_range(0, 19);
			if (r < 5)
				it.event_code = sesq_pkg::EV_TOUCH;
			else if (r < 10)
				it.event_code = sesq_pkg::EV_CONFIRM;
			else if (r < 14)
				it.event_code = sesq_pkg::EV_ERROR;
			else if (r < 17)
				it.event_code = sesq_pkg::EV_ASTART;
			else if (r < 18)
				it.event_code = sesq_pkg::EV_ASTOP;
		end else if (k < 75) begin
			it.action = sesq_pkg::ACT_TICK;
		end else if (k < 87) begin
			it.action = sesq_pkg::ACT_PREVIEW;
		end else begin
			it.action     = sesq_pkg::ACT_MUTE;
			it.mute_value = ($urandom_range(0, 2) == 0);
		end
		return it;
	endfunction

	task automatic offer(req_item_t it, int n_typed, sesq_pkg::res_t t0, sesq_pkg::res_t t1);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req.valid           <= 1'b1;
		req.action          <= it.action;
		req.event_code      <= it.event_code;
		req.preview_variant <= it.pvar;
		req.mute_value      <= it.mute_value;
		req.now_ms          <= it.now_ms;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		compute_buzzer_cmds(it);
		if (n_typed == 0) begin
			foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
		end else begin
			expected_cmds.push_back(t0);
			if (n_typed > 1)
				expected_cmds.push_back(t1);
		end
	endtask

	task automatic drain_wait(int extra);
		req.valid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(logic [sesq_pkg::CFG_IDX_W-1:0] idx,
	                         logic [sesq_pkg::CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		apply_reg(idx, d);
	endtask

	task automatic configure(int ph);
		logic [sesq_pkg::CFG_DATA_W-1:0] vals [7];
		int i;
		if (ph == 1) begin
			vals = '{7'd15, 7'd127, 7'd100, 7'd7, 7'd6, 7'd5, 7'd4};
		end else if (ph == 2) begin
			vals = '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
		end else begin
			vals[0] = (ph % 2) ? 7'd15 : 7'($urandom_range(0, 127));
			for (i = 1; i < 7; i++)
				vals[i] = 7'($urandom_range(0, 127));
		end
		write_reg(sesq_pkg::REG_ENABLE, vals[0]);
		write_reg(sesq_pkg::REG_SYS_VOL, vals[1]);
		write_reg(sesq_pkg::REG_ALARM_VOL, vals[2]);
		write_reg(sesq_pkg::REG_MEL_TOUCH, vals[3]);
		write_reg(sesq_pkg::REG_MEL_CONF, vals[4]);
		write_reg(sesq_pkg::REG_MEL_ERROR, vals[5]);
		write_reg(sesq_pkg::REG_MEL_ALARM, vals[6]);
		if (ph == 2)
			write_reg(REG_SPARE, 7'($urandom_range(0, 127)));
		cfg_we <= 1'b0;
	endtask

	// stimulus
	initial begin
		sesq_pkg::res_t done0;
		sesq_pkg::res_t done1;
		sesq_pkg::res_t stop_r;
		int ph;
		arst_n              = 1'b0;
		req.valid          <= 1'b0;
		req.action         <= sesq_pkg::ACT_TICK;
		req.event_code     <= EV_NONE;
		req.preview_variant <= 3'd0;
		req.mute_value     <= 1'b0;
		req.now_ms         <= 32'd0;
		cfg_we             <= 1'b0;
		cfg_index          <= sesq_pkg::REG_ENABLE;
		cfg_data           <= 7'd0;
		err_count     = 0;
		no_idle       = 1'b0;
		now_base      = 32'd5000;
		cfg_enable    = 4'hF;
		cfg_sys_vol   = 7'd70;
		cfg_alarm_vol = 7'd70;
		foreach (cfg_mel[i]) cfg_mel[i] = 3'd0;
		foreach (ring_ev[i]) ring_ev[i] = 3'd0;
		ring_head  = 0;
		ring_tail  = 0;
		alarm_on   = 1'b0;
		alarm_held = 1'b0;
		is_muted   = 1'b0;
		resume_at  = 32'd0;

		done0  = cmd_res(sesq_pkg::CMD_DONE, 7'd0, 2'd0, 3'd0, 1'b0, 1'b1);
		done1  = cmd_res(sesq_pkg::CMD_DONE, 7'd0, 2'd0, 3'd0, 1'b1, 1'b1);
		stop_r = cmd_res(sesq_pkg::CMD_STOP, 7'd0, 2'd0, 3'd0, 1'b0, 1'b0);
		add_row(sesq_pkg::ACT_TICK,    EV_NONE,   3'd0, 1'b0, 32'd0, 1, done0, '0);
		add_row(sesq_pkg::ACT_POST,    EV_NONE,   3'd0, 1'b0, 32'd0, 1, done0, '0);
		add_row(sesq_pkg::ACT_POST,    EV_SPARE7, 3'd0, 1'b0, 32'd0, 1, done0, '0);
		add_row(sesq_pkg::ACT_PREVIEW, EV_NONE,   3'd7, 1'b0, 32'd0, 1, done0, '0);
		add_row(sesq_pkg::ACT_POST, sesq_pkg::EV_TOUCH, 3'd0, 1'b0, 32'd0, 1, done1, '0);
		// second touch while one is queued is refused
		add_row(sesq_pkg::ACT_POST, sesq_pkg::EV_TOUCH, 3'd0, 1'b0, 32'd0, 1, done0, '0);
		add_row(sesq_pkg::ACT_POST, sesq_pkg::EV_CONFIRM, 3'd0, 1'b0, 32'd0, 0, '0, '0);
		add_row(sesq_pkg::ACT_POST, sesq_pkg::EV_ERROR, 3'd0, 1'b0, 32'd0, 0, '0, '0);
		add_row(sesq_pkg::ACT_TICK, EV_NONE, 3'd0, 1'b0, 32'd100, 0, '0, '0);
		add_row(sesq_pkg::ACT_POST, sesq_pkg::EV_ASTART, 3'd0, 1'b0, 32'd0, 2, stop_r, done1);
		add_row(sesq_pkg::ACT_TICK, EV_NONE, 3'd0, 1'b0, 32'd1000, 0, '0, '0);
		add_row(sesq_pkg::ACT_POST, sesq_pkg::EV_TOUCH, 3'd0, 1'b0, 32'd0, 0, '0, '0);
		// touch over the alarm: suspended until 2000 + 17 + 30
		add_row(sesq_pkg::ACT_TICK, EV_NONE, 3'd0, 1'b0, 32'd2000, 0, '0, '0);
		add_row(sesq_pkg::ACT_TICK, EV_NONE, 3'd0, 1'b0, 32'd2046, 1, done0, '0);
		add_row(sesq_pkg::ACT_TICK, EV_NONE, 3'd0, 1'b0, 32'd2047, 0, '0, '0);
		// resume time wraps past 2^32
		add_row(sesq_pkg::ACT_POST, sesq_pkg::EV_TOUCH, 3'd0, 1'b0, 32'd0, 0, '0, '0);
		add_row(sesq_pkg::ACT_TICK, EV_NONE, 3'd0, 1'b0, 32'hFFFF_FFF0, 0, '0, '0);
		add_row(sesq_pkg::ACT_TICK, EV_NONE, 3'd0, 1'b0, 32'hFFFF_FFFF, 0, '0, '0);
		add_row(sesq_pkg::ACT_PREVIEW, sesq_pkg::EV_ASTART, 3'd7, 1'b0, 32'd0, 0, '0, '0);
		add_row(sesq_pkg::ACT_PREVIEW, sesq_pkg::EV_ERROR, 3'd5, 1'b0, 32'd3000, 0, '0, '0);
		add_row(sesq_pkg::ACT_MUTE, EV_NONE, 3'd0, 1'b1, 32'd0, 2, stop_r, done0);
		add_row(sesq_pkg::ACT_PREVIEW, sesq_pkg::EV_CONFIRM, 3'd3, 1'b0, 32'd0, 1, done0, '0);
		add_row(sesq_pkg::ACT_MUTE, EV_NONE, 3'd0, 1'b0, 32'd0, 0, '0, '0);
		add_row(sesq_pkg::ACT_POST, sesq_pkg::EV_ASTOP, 3'd0, 1'b0, 32'd0, 2, stop_r, done0);
		add_row(sesq_pkg::ACT_PREVIEW, EV_SPARE6, 3'd2, 1'b0, 32'd0, 1, done0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].it, dir_rows[i].n_typed, dir_rows[i].r0, dir_rows[i].r1);

		for (ph = 1; ph <= 6; ph++) begin
			drain_wait(4);
			configure(ph);
			if (ph == 6)
				no_idle = 1'b1;
			repeat (PHASE_ITEMS) offer(random_item(), 0, '0, '0);
		end

		drain_wait(20);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stall bursts, one long hold to back up the request side
	initial begin
		int stall_left;
		bit held_once;
		stall_left = 0;
		held_once  = 1'b0;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held_once && res_seen >= 150) begin
				held_once = 1'b1;
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// compare each result item with the oldest expectation
	always @(posedge clk) begin
		sesq_pkg::res_t got;
		sesq_pkg::res_t want;
		if (arst_n && res.valid && res.ready) begin
			got = {res.command, res.volume, res.melody_type, res.melody_variant,
			       res.post_accepted, res.last};
			res_seen++;
			if (expected_cmds.size() == 0) begin
				log_error($sformatf("result %0d not expected: %s", res_seen, show_cmd(got)));
			end else begin
				want = expected_cmds.pop_front();
				if (got.command !== want.command || got.volume !== want.volume ||
				    got.melody_type !== want.melody_type ||
				    got.melody_variant !== want.melody_variant ||
				    got.post_accepted !== want.post_accepted || got.last !== want.last)
					log_error($sformatf("result %0d: got %s, expected %s", res_seen,
					                    show_cmd(got), show_cmd(want)));
			end
		end
	end

	initial res_seen = 0;

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (res.valid && res.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule

FILE: files.f
src/sesq_pkg.sv
src/sesq_if.sv
src/sesq_ring.sv
src/sesq_out_stage.sv
src/sound_event_sequencer.sv
test/tb_sound_event_sequencer.sv
